[design/bimms_pkg.sv]
// Shared constants and types for the boot information memory-map summer.
package bimms_pkg;

    localparam int MAX_TAGS    = 64;
    localparam int MAX_ENTRIES = 32;

    localparam int TAG_CNT_W   = $clog2(MAX_TAGS + 1);
    localparam int ENTRY_CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam logic [63:0] FALLBACK_RESET = 64'd134217728;   // 128 MiB

    localparam logic [31:0] MIN_TOTAL     = 32'd16;
    localparam logic [31:0] FIRST_TAG     = 32'd8;
    localparam logic [31:0] TAG_HDR_BYTES = 32'd8;
    localparam logic [31:0] MAP_HDR_BYTES = 32'd16;
    localparam logic [31:0] MIN_ENTRY     = 32'd24;
    localparam logic [31:0] MAP_TAG_TYPE  = 32'd6;
    localparam logic [31:0] USABLE_TYPE   = 32'd1;

    // walk phases
    localparam logic [2:0] PH_TOTAL = 3'd0;
    localparam logic [2:0] PH_TYPE  = 3'd1;
    localparam logic [2:0] PH_SIZE  = 3'd2;
    localparam logic [2:0] PH_ESIZE = 3'd3;
    localparam logic [2:0] PH_ENTRY = 3'd4;
    localparam logic [2:0] PH_DONE  = 3'd5;

    typedef struct packed {
        logic [63:0] sum;
        logic        unfinished;
    } walk_status_t;

endpackage

[design/bimms_ifs.sv]
// Stream interfaces for the info words in and the results out.
interface bimms_info_if;
    logic        valid;
    logic        ready;
    logic [31:0] info_word;
    logic        last_word;

    modport source (output valid, output info_word, output last_word, input ready);
    modport sink   (input valid, input info_word, input last_word, output ready);
endinterface

interface bimms_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] memory_bytes;
    logic        used_fallback;
    logic        walk_unfinished;

    modport source (output valid, output memory_bytes, output used_fallback,
                    output walk_unfinished, input ready);
    modport sink   (input valid, input memory_bytes, input used_fallback,
                    input walk_unfinished, output ready);
endinterface

[design/bimms_walk.sv]
// Tag walker and usable-length accumulator, one word per step.
module bimms_walk (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [31:0]           word,
    input  logic                  last,
    output bimms_pkg::walk_status_t status
);
    import bimms_pkg::*;

    logic [31:0]            pos_reg,         pos_next;
    logic [31:0]            total_reg,       total_next;
    logic [31:0]            tag_start_reg,   tag_start_next;
    logic [31:0]            tag_bytes_reg,   tag_bytes_next;
    logic [TAG_CNT_W-1:0]   tags_reg,        tags_next;
    logic [31:0]            entry_bytes_reg, entry_bytes_next;
    logic [31:0]            entry_start_reg, entry_start_next;
    logic [ENTRY_CNT_W-1:0] entries_reg,     entries_next;
    logic [31:0]            len_lo_reg,      len_lo_next;
    logic [31:0]            len_hi_reg,      len_hi_next;
    logic [63:0]            sum_reg,         sum_next;
    logic [2:0]             phase_reg,       phase_next;
    logic                   is_map_reg,      is_map_next;

    logic [33:0]            round_size;
    logic [33:0]            bt_off;
    logic [31:0]            total_eff;
    logic                   bt_ok;
    logic [33:0]            tag_end;
    logic [33:0]            next_entry_end;
    logic [ENTRY_CNT_W:0]   entries_inc;

    always_comb
    begin
        round_size     = ({2'b00, word} + 34'd7) & ~34'd7;
        total_eff      = (phase_reg == PH_TOTAL) ? word : total_reg;
        bt_off         = (phase_reg == PH_TOTAL) ? {2'b00, FIRST_TAG}
                                                 : {2'b00, tag_start_reg} + round_size;
        // next tag header must fit and the tag budget must not be spent
        bt_ok          = (bt_off + {2'b00, TAG_HDR_BYTES} <= {2'b00, total_eff})
                         && (tags_reg < TAG_CNT_W'(MAX_TAGS));
        tag_end        = {2'b00, tag_start_reg} + {2'b00, tag_bytes_reg};
        // end of the next entry: another whole entry must still fit
        next_entry_end = {2'b00, entry_start_reg} + {2'b00, entry_bytes_reg}
                         + {2'b00, entry_bytes_reg};
        entries_inc    = {1'b0, entries_reg} + 1'b1;
    end

    always_comb
    begin
        pos_next         = pos_reg + 32'd4;
        total_next       = total_reg;
        tag_start_next   = tag_start_reg;
        tag_bytes_next   = tag_bytes_reg;
        tags_next        = tags_reg;
        entry_bytes_next = entry_bytes_reg;
        entry_start_next = entry_start_reg;
        entries_next     = entries_reg;
        len_lo_next      = len_lo_reg;
        len_hi_next      = len_hi_reg;
        sum_next         = sum_reg;
        phase_next       = phase_reg;
        is_map_next      = is_map_reg;

        case (phase_reg)
            PH_TOTAL:
            begin
                total_next = word;
                if (word < MIN_TOTAL || word[2:0] != 3'd0)
                begin
                    phase_next = PH_DONE;
                end
                else if (bt_ok)
                begin
                    tag_start_next = bt_off[31:0];
                    tags_next      = tags_reg + 1'b1;
                    phase_next     = PH_TYPE;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_TYPE:
            begin
                if (pos_reg == tag_start_reg)
                begin
                    is_map_next = (word == MAP_TAG_TYPE);
                    phase_next  = PH_SIZE;
                end
            end
            PH_SIZE:
            begin
                if (pos_reg == tag_start_reg + 32'd4)
                begin
                    if (word < TAG_HDR_BYTES
                        || {2'b00, tag_start_reg} + {2'b00, word} > {2'b00, total_reg})
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        tag_bytes_next = word;
                        if (is_map_reg && word >= MAP_HDR_BYTES)
                        begin
                            phase_next = PH_ESIZE;
                        end
                        else if (bt_ok)
                        begin
                            tag_start_next = bt_off[31:0];
                            tags_next      = tags_reg + 1'b1;
                            phase_next     = PH_TYPE;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                end
            end
            PH_ESIZE:
            begin
                if (pos_reg == tag_start_reg + 32'd8)
                begin
                    if (word >= MIN_ENTRY && word <= tag_bytes_reg && word[1:0] == 2'd0)
                    begin
                        entry_bytes_next = word;
                        entries_next     = '0;
                        entry_start_next = tag_start_reg + MAP_HDR_BYTES;
                        // no whole entry fits behind the map header
                        if ({2'b00, MAP_HDR_BYTES} + {2'b00, word} > {2'b00, tag_bytes_reg})
                            phase_next = PH_DONE;
                        else
                            phase_next = PH_ENTRY;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
            end
            PH_ENTRY:
            begin
                if (pos_reg == entry_start_reg + 32'd8)
                begin
                    len_lo_next = word;
                end
                else if (pos_reg == entry_start_reg + 32'd12)
                begin
                    len_hi_next = word;
                end
                else if (pos_reg == entry_start_reg + 32'd16)
                begin
                    if (word == USABLE_TYPE)
                        sum_next = sum_reg + {len_hi_reg, len_lo_reg};
                    entries_next = entries_inc[ENTRY_CNT_W-1:0];
                    if (entries_inc >= (ENTRY_CNT_W + 1)'(MAX_ENTRIES)
                        || next_entry_end > tag_end)
                        phase_next = PH_DONE;
                    else
                        entry_start_next = entry_start_reg + entry_bytes_reg;
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    assign status.sum        = sum_next;
    assign status.unfinished = (phase_next != PH_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            total_reg       <= '0;
            tag_start_reg   <= FIRST_TAG;
            tag_bytes_reg   <= '0;
            tags_reg        <= '0;
            entry_bytes_reg <= '0;
            entry_start_reg <= '0;
            entries_reg     <= '0;
            len_lo_reg      <= '0;
            len_hi_reg      <= '0;
            sum_reg         <= '0;
            phase_reg       <= PH_TOTAL;
            is_map_reg      <= 1'b0;
        end
        else if (step && last)
        begin
            // a result ends the structure; next word is word 0 of a new one
            pos_reg         <= '0;
            total_reg       <= '0;
            tag_start_reg   <= FIRST_TAG;
            tag_bytes_reg   <= '0;
            tags_reg        <= '0;
            entry_bytes_reg <= '0;
            entry_start_reg <= '0;
            entries_reg     <= '0;
            len_lo_reg      <= '0;
            len_hi_reg      <= '0;
            sum_reg         <= '0;
            phase_reg       <= PH_TOTAL;
            is_map_reg      <= 1'b0;
        end
        else if (step)
        begin
            pos_reg         <= pos_next;
            total_reg       <= total_next;
            tag_start_reg   <= tag_start_next;
            tag_bytes_reg   <= tag_bytes_next;
            tags_reg        <= tags_next;
            entry_bytes_reg <= entry_bytes_next;
            entry_start_reg <= entry_start_next;
            entries_reg     <= entries_next;
            len_lo_reg      <= len_lo_next;
            len_hi_reg      <= len_hi_next;
            sum_reg         <= sum_next;
            phase_reg       <= phase_next;
            is_map_reg      <= is_map_next;
        end
    end

endmodule

[design/boot_info_memory_map_summer.sv]
// Boot information memory-map summer: takes one 32-bit info word per cycle and
// walks the tag list as words arrive, summing the lengths of usable entries of
// the first valid memory-map tag. A word is taken every cycle unless a last
// word is held; each word passes an input register and is folded into the walk
// state as it leaves it, and on the marked last word the result also lands in
// the output register. Words keep flowing while a result waits; only a second
// last word stalls behind an untaken result. cfg_data written with cfg_write
// sets the fallback size.
module boot_info_memory_map_summer (
    input  logic                   clk,
    input  logic                   rst_n,
    bimms_info_if.sink             info,
    bimms_result_if.source         result,
    input  logic                   cfg_write,
    input  logic [63:0]            cfg_data
);
    import bimms_pkg::*;

    logic        in_vld_reg;
    logic [31:0] in_word_reg;
    logic        in_last_reg;
    logic        out_vld_reg;
    logic [63:0] out_bytes_reg;
    logic        out_fallback_reg;
    logic        out_unfinished_reg;
    logic [63:0] fallback_reg;

    logic         out_free;
    logic         proceed;
    walk_status_t status;

    assign out_free   = !out_vld_reg || result.ready;
    assign proceed    = in_vld_reg && (!in_last_reg || out_free);
    assign info.ready = !in_vld_reg || proceed;

    bimms_walk u_walk (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (proceed),
        .word   (in_word_reg),
        .last   (in_last_reg),
        .status (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
            fallback_reg <= FALLBACK_RESET;
        end
        else
        begin
            if (info.ready)
                in_vld_reg <= info.valid;
            if (proceed && in_last_reg)
                out_vld_reg <= 1'b1;
            else if (result.ready)
                out_vld_reg <= 1'b0;
            if (cfg_write)
                fallback_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (info.ready && info.valid)
        begin
            in_word_reg <= info.info_word;
            in_last_reg <= info.last_word;
        end
        if (proceed && in_last_reg)
        begin
            out_bytes_reg      <= (status.sum != 64'd0) ? status.sum : fallback_reg;
            out_fallback_reg   <= (status.sum == 64'd0);
            out_unfinished_reg <= status.unfinished;
        end
    end

    assign result.valid           = out_vld_reg;
    assign result.memory_bytes    = out_bytes_reg;
    assign result.used_fallback   = out_fallback_reg;
    assign result.walk_unfinished = out_unfinished_reg;

endmodule

[design/bimms_checker.sv]
// Port-level checks for the memory-map summer, bound to the top level.
module bimms_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        in_last,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] out_bytes,
    input  logic        out_fallback,
    input  logic        out_unfinished
);
    // last words taken but not yet delivered as results
    logic [1:0] pending_reg;
    logic       last_in;
    logic       res_out;

    assign last_in = in_valid && in_ready && in_last;
    assign res_out = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else if (last_in && !res_out)
            pending_reg <= pending_reg + 2'd1;
        else if (res_out && !last_in)
            pending_reg <= pending_reg - 2'd1;
    end

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_bytes)
        && $stable(out_fallback) && $stable(out_unfinished))
        else $error("result word changed while stalled");

    a_sum_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_fallback |-> out_bytes != 64'd0)
        else $error("summed result of zero reported without fallback");

    a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result word with no last word taken");

    // a result leaving frees a stage for a last word in the same cycle
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 2'd2 && !res_out |-> !last_in)
        else $error("more last words in flight than stages to hold them");

endmodule

bind boot_info_memory_map_summer bimms_checker u_bimms_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (info.valid),
    .in_ready       (info.ready),
    .in_last        (info.last_word),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_bytes      (result.memory_bytes),
    .out_fallback   (result.used_fallback),
    .out_unfinished (result.walk_unfinished)
);

[verif/boot_info_memory_map_summer_tb.sv]
// Self-checking testbench for the boot information memory-map summer.
module boot_info_memory_map_summer_tb;
    import bimms_pkg::*;

    typedef struct packed {
        logic [63:0] memory_bytes;
        logic        used_fallback;
        logic        walk_unfinished;
    } summary_t;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
        logic        typed;
        summary_t    want;
    } stim_row_t;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASES         = 8;
    localparam int PHASE_WORDS    = 190;
    localparam int REPORT_LIMIT   = 10;

    localparam summary_t NO_SUM       = '0;
    localparam summary_t FB_SUM       = '{FALLBACK_RESET, 1'b1, 1'b0};
    localparam summary_t FB_OPEN_SUM  = '{FALLBACK_RESET, 1'b1, 1'b1};
    localparam summary_t ALL_ONES_SUM = '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0};

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [63:0] cfg_data;

    bimms_info_if   info_bus ();
    bimms_result_if result_bus ();

    boot_info_memory_map_summer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .info      (info_bus.sink),
        .result    (result_bus.source),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    // walk state of the predictor
    logic [63:0] fallback_size;
    logic [31:0] walk_pos;
    logic [31:0] walk_total;
    logic [31:0] tag_at;
    logic [31:0] tag_len;
    logic [6:0]  tag_count;
    logic [31:0] entry_len;
    logic [31:0] entry_at;
    logic [5:0]  entries_seen;
    logic [31:0] length_lo;
    logic [31:0] length_hi;
    logic [63:0] usable_sum;
    logic [2:0]  walk_ph;
    logic        map_tag;

    summary_t    pending_sums[$];
    logic [31:0] frame[$];
    int          size_slots[$];
    idle_mode_t  idle_mode;
    int          fault_count;
    int          stall_cycles;

    // short structures with the expected result typed in where it is obvious
    stim_row_t directed_rows [24] = '{
        '{32'h0000_0000, 1'b1, 1'b1, FB_SUM},        // total size zero
        '{32'hFFFF_FFFF, 1'b1, 1'b1, FB_SUM},        // total size not a multiple of 8
        '{32'd16,        1'b1, 1'b1, FB_OPEN_SUM},   // ends while waiting for a tag
        // one map tag, one usable entry of maximum length
        '{32'd48,        1'b0, 1'b0, NO_SUM},
        '{32'h0000_0000, 1'b0, 1'b0, NO_SUM},
        '{32'd6,         1'b0, 1'b0, NO_SUM},
        '{32'd40,        1'b0, 1'b0, NO_SUM},
        '{32'd24,        1'b0, 1'b0, NO_SUM},
        '{32'h0000_0000, 1'b0, 1'b0, NO_SUM},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, NO_SUM},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, NO_SUM},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, NO_SUM},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, NO_SUM},
        '{32'd1,         1'b0, 1'b0, NO_SUM},
        '{32'h0000_0000, 1'b1, 1'b1, ALL_ONES_SUM},
        // tag size below the header
        '{32'd24,        1'b0, 1'b0, NO_SUM},
        '{32'h0000_0000, 1'b0, 1'b0, NO_SUM},
        '{32'd1,         1'b0, 1'b0, NO_SUM},
        '{32'd4,         1'b1, 1'b1, FB_SUM},
        // entry size not a multiple of 4
        '{32'd32,        1'b0, 1'b0, NO_SUM},
        '{32'h0000_0000, 1'b0, 1'b0, NO_SUM},
        '{32'd6,         1'b0, 1'b0, NO_SUM},
        '{32'd24,        1'b0, 1'b0, NO_SUM},
        '{32'd26,        1'b1, 1'b1, FB_SUM}
    };

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void restart_walk();
        walk_pos     = '0;
        walk_total   = '0;
        tag_at       = FIRST_TAG;
        tag_len      = '0;
        tag_count    = '0;
        entry_len    = '0;
        entry_at     = '0;
        entries_seen = '0;
        length_lo    = '0;
        length_hi    = '0;
        usable_sum   = '0;
        walk_ph      = PH_TOTAL;
        map_tag      = 1'b0;
    endfunction

    function automatic void open_tag(input logic [63:0] off);
        if (off + 64'd8 > {32'd0, walk_total} || tag_count >= MAX_TAGS)
        begin
            walk_ph = PH_DONE;
        end
        else
        begin
            tag_at    = off[31:0];
            tag_count = tag_count + 7'd1;
            walk_ph   = PH_TYPE;
        end
    endfunction

    function automatic logic [31:0] map_entries();
        logic [31:0] n;
        n = (tag_len - MAP_HDR_BYTES) / entry_len;
        return (n > MAX_ENTRIES) ? 32'(MAX_ENTRIES) : n;
    endfunction

    // advance the walk by one word; on the last word hand back the summary
    function automatic void fold_word(input logic [31:0] w, input logic last,
                                      output bit has_sum, output summary_t sum);
        has_sum = 1'b0;
        sum     = NO_SUM;
        case (walk_ph)
            PH_TOTAL:
            begin
                walk_total = w;
                if (w < MIN_TOTAL || w[2:0] != 3'd0)
                    walk_ph = PH_DONE;
                else
                    open_tag({32'd0, FIRST_TAG});
            end
            PH_TYPE:
            begin
                if (walk_pos == tag_at)
                begin
                    map_tag = (w == MAP_TAG_TYPE);
                    walk_ph = PH_SIZE;
                end
            end
            PH_SIZE:
            begin
                if (walk_pos == tag_at + 32'd4)
                begin
                    if (w < TAG_HDR_BYTES || {32'd0, tag_at} + {32'd0, w} > {32'd0, walk_total})
                    begin
                        walk_ph = PH_DONE;
                    end
                    else
                    begin
                        tag_len = w;
                        if (map_tag && w >= MAP_HDR_BYTES)
                            walk_ph = PH_ESIZE;
                        else
                            open_tag({32'd0, tag_at} + (({32'd0, w} + 64'd7) & ~64'd7));
                    end
                end
            end
            PH_ESIZE:
            begin
                if (walk_pos == tag_at + 32'd8)
                begin
                    if (w >= MIN_ENTRY && w <= tag_len && w[1:0] == 2'd0)
                    begin
                        entry_len    = w;
                        entries_seen = '0;
                        entry_at     = tag_at + MAP_HDR_BYTES;
                        walk_ph      = (map_entries() == 0) ? PH_DONE : PH_ENTRY;
                    end
                    else
                    begin
                        walk_ph = PH_DONE;
                    end
                end
            end
            PH_ENTRY:
            begin
                if (walk_pos == entry_at + 32'd8)
                begin
                    length_lo = w;
                end
                else if (walk_pos == entry_at + 32'd12)
                begin
                    length_hi = w;
                end
                else if (walk_pos == entry_at + 32'd16)
                begin
                    if (w == USABLE_TYPE)
                        usable_sum = usable_sum + {length_hi, length_lo};
                    entries_seen = entries_seen + 6'd1;
                    if ({26'd0, entries_seen} >= map_entries())
                        walk_ph = PH_DONE;
                    else
                        entry_at = entry_at + entry_len;
                end
            end
            default:
            begin
                walk_ph = PH_DONE;
            end
        endcase
        walk_pos = walk_pos + 32'd4;
        if (last)
        begin
            has_sum = 1'b1;
            if (usable_sum != 0)
                sum = '{usable_sum, 1'b0, walk_ph != PH_DONE};
            else
                sum = '{fallback_size, 1'b1, walk_ph != PH_DONE};
            restart_walk();
        end
    endfunction

    function automatic bit sender_holds();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 80;
            IDLE_BOTH:   return $urandom_range(0, 99) < 23;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(0, 99) < 80;
            IDLE_BOTH:     return $urandom_range(0, 99) < 23;
            default:       return 1'b0;
        endcase
    endfunction

    // called just after a falling edge, returns just after one
    task automatic send_word(input logic [31:0] w, input logic last,
                             input logic typed, input summary_t want);
        bit       has_sum;
        summary_t sum;
        while (sender_holds())
        begin
            info_bus.valid <= 1'b0;
            @(negedge clk);
        end
        info_bus.valid     <= 1'b1;
        info_bus.info_word <= w;
        info_bus.last_word <= last;
        forever
        begin
            @(posedge clk);
            if (info_bus.ready)
                break;
        end
        fold_word(w, last, has_sum, sum);
        if (has_sum)
            pending_sums.push_back(typed ? want : sum);
        @(negedge clk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++)
            send_word(frame[i], i == frame.size() - 1, 1'b0, NO_SUM);
    endtask

    // let every result drain and the block go quiet before touching the register
    task automatic settle();
        info_bus.valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_fallback(input logic [63:0] v);
        cfg_data  <= v;
        cfg_write <= 1'b1;
        @(negedge clk);
        cfg_write <= 1'b0;
        fallback_size = v;
    endtask

    function automatic logic [31:0] rand_length();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_tag_type();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return $urandom_range(0, 21);
    endfunction

    function automatic void add_plain_tag(input logic [31:0] code, input int unsigned size);
        int unsigned padded;
        padded = (size + 7) & ~32'd7;
        size_slots.push_back(frame.size() + 1);
        frame.push_back(code);
        frame.push_back(size);
        for (int unsigned b = 8; b < padded; b += 4)
            frame.push_back($urandom);
    endfunction

    function automatic void add_map_tag(input bit bad_esize);
        int unsigned esize;
        int unsigned n;
        int unsigned extra;
        int unsigned size;
        logic [31:0] esize_word;
        esize = ($urandom_range(0, 3) == 0) ? 24 + 4 * $urandom_range(1, 4) : 24;
        n     = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 5);
        extra = ($urandom_range(0, 2) == 0) ? 4 * $urandom_range(0, esize / 4 - 1) : 0;
        size  = 16 + n * esize + extra;
        esize_word = esize;
        if (bad_esize)
        begin
            case ($urandom_range(0, 3))
                0:       esize_word = esize + $urandom_range(1, 3);
                1:       esize_word = 4 * $urandom_range(0, 5);
                2:       esize_word = size + 4 * $urandom_range(1, 4);
                default: esize_word = $urandom;
            endcase
        end
        size_slots.push_back(frame.size() + 1);
        frame.push_back(MAP_TAG_TYPE);
        frame.push_back(size);
        frame.push_back(esize_word);
        frame.push_back($urandom);
        for (int unsigned e = 0; e < n; e++)
        begin
            frame.push_back($urandom);
            frame.push_back($urandom);
            frame.push_back(rand_length());
            frame.push_back(rand_length());
            if ($urandom_range(0, 9) < 6)
                frame.push_back(USABLE_TYPE);
            else if ($urandom_range(0, 1) == 0)
                frame.push_back($urandom_range(0, 5));
            else
                frame.push_back($urandom);
            for (int unsigned b = 20; b < esize; b += 4)
                frame.push_back($urandom);
        end
        for (int unsigned b = 0; b < extra; b += 4)
            frame.push_back($urandom);
        if (size % 8 != 0)
            frame.push_back($urandom);
    endfunction

    function automatic void build_structure(input bit with_map, input bit bad_esize,
                                            input int unsigned lead, input int unsigned after,
                                            input bit tiny_tags);
        logic [31:0] code;
        int unsigned size;
        frame.delete();
        size_slots.delete();
        frame.push_back(32'd0);
        frame.push_back($urandom);
        for (int unsigned t = 0; t < lead + after + 1; t++)
        begin
            if (with_map && t == lead)
                add_map_tag(bad_esize);
            code = rand_tag_type();
            if (tiny_tags)
                size = 8;
            else if (code == MAP_TAG_TYPE)
                size = $urandom_range(8, 15);   // too short to count as a memory map
            else
                size = $urandom_range(8, 40);
            if (t == lead + after)
                add_plain_tag(32'd0, 8);        // end tag
            else
                add_plain_tag(code, size);
        end
        frame[0] = frame.size() * 4;
    endfunction

    function automatic logic [31:0] broken_tag_size(input int slot);
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 7);
            1:       return 32'hFFFF_FFF8;
            2:       return $urandom | 32'h8000_0000;
            default: return frame[0] - (slot - 1) * 4 + $urandom_range(1, 8);
        endcase
    endfunction

    function automatic void build_random_frame();
        int unsigned pick;
        int unsigned keep;
        int          slot;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            build_structure($urandom_range(0, 9) != 0, 1'b0, $urandom_range(0, 3),
                            $urandom_range(0, 2), 1'b0);
            if (pick < 12)
            begin
                repeat ($urandom_range(1, 3)) frame.push_back($urandom);
            end
            else if (pick >= 60)
            begin
                // stream ends before the walk is through
                keep = $urandom_range(1, frame.size() - 1);
                while (frame.size() > keep)
                    frame.delete(frame.size() - 1);
            end
        end
        else if (pick < 78)
        begin
            build_structure(1'b1, 1'b1, $urandom_range(0, 2), $urandom_range(0, 1), 1'b0);
        end
        else if (pick < 86)
        begin
            build_structure($urandom_range(0, 1), 1'b0, $urandom_range(0, 3),
                            $urandom_range(0, 2), 1'b0);
            slot = size_slots[$urandom_range(0, size_slots.size() - 1)];
            frame[slot] = broken_tag_size(slot);
        end
        else if (pick < 91)
        begin
            frame.delete();
            if ($urandom_range(0, 1) == 0)
                frame.push_back($urandom_range(0, 15));
            else
                frame.push_back(($urandom & ~32'd7) | $urandom_range(1, 7));
            repeat ($urandom_range(0, 4)) frame.push_back($urandom);
        end
        else if (pick < 95)
        begin
            frame.delete();
            repeat ($urandom_range(1, 10)) frame.push_back($urandom);
        end
        else
        begin
            // runs up to or past the tag limit
            build_structure(1'b0, 1'b0, $urandom_range(60, 66), 0, 1'b1);
        end
    endfunction

    function automatic logic [63:0] phase_fallback(input int p);
        case (p)
            1:       return 64'h0;
            2:       return 64'hFFFF_FFFF_FFFF_FFFF;
            3:       return 64'h1;
            4:       return FALLBACK_RESET;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_bus.ready <= !receiver_stalls();
        end
    end

    always @(posedge clk)
    begin
        summary_t seen;
        summary_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            seen = '{result_bus.memory_bytes, result_bus.used_fallback,
                     result_bus.walk_unfinished};
            if (pending_sums.size() == 0)
            begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("unexpected result word: bytes %h fallback %b unfinished %b",
                             seen.memory_bytes, seen.used_fallback, seen.walk_unfinished);
            end
            else
            begin
                want = pending_sums.pop_front();
                if (seen.memory_bytes != want.memory_bytes
                    || seen.used_fallback != want.used_fallback
                    || seen.walk_unfinished != want.walk_unfinished)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("result mismatch: expected %h/%b/%b got %h/%b/%b",
                                 want.memory_bytes, want.used_fallback, want.walk_unfinished,
                                 seen.memory_bytes, seen.used_fallback, seen.walk_unfinished);
                end
            end
        end
    end

    // nothing moving on either side for too long means a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((info_bus.valid && info_bus.ready) || (result_bus.valid && result_bus.ready))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
                if (stall_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("boot_info_memory_map_summer regression: fail");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int unsigned phase_words;
        rst_n              = 1'b0;
        cfg_write          = 1'b0;
        cfg_data           = '0;
        info_bus.valid     = 1'b0;
        info_bus.info_word = '0;
        info_bus.last_word = 1'b0;
        fault_count        = 0;
        stall_cycles       = 0;
        idle_mode          = IDLE_NONE;
        fallback_size      = FALLBACK_RESET;
        restart_walk();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].want);

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            if (p != 0)
                write_fallback(phase_fallback(p));
            idle_mode   = idle_mode_t'(p % 4);
            phase_words = 0;
            while (phase_words < PHASE_WORDS)
            begin
                build_random_frame();
                phase_words += frame.size();
                send_frame();
            end
        end

        info_bus.valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fault_count == 0)
            $display("boot_info_memory_map_summer regression: pass");
        else
            $display("boot_info_memory_map_summer regression: fail");
        $finish;
    end

endmodule

[files.f]
design/bimms_pkg.sv
design/bimms_ifs.sv
design/bimms_walk.sv
design/boot_info_memory_map_summer.sv
design/bimms_checker.sv
verif/boot_info_memory_map_summer_tb.sv
